// File: rtl/slbs_pkg.sv
// Shared types and constants of the stack-load bubble sorter.
// No dependencies; used by every module of the block.
`default_nettype none
package slbs_pkg;

    localparam int DEPTH    = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic REG_SORT_DESC = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_PUSH_LAST,
        CMD_DROP,
        CMD_DROP_LAST
    } cmd_kind_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        cmd_kind_t                kind;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        back_state_t      state;
        logic [CNT_W-1:0] count;
    } back_status_t;

endpackage
`default_nettype wire

// File: rtl/slbs_front.sv
// Front end: accepts requests and classifies each as push or drop, last or not.
// Depends on slbs_pkg; feeds slbs_queue.
`default_nettype none
module slbs_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [slbs_pkg::DATA_W-1:0] s_value,
    input  wire logic                               s_last,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output slbs_pkg::cmd_t                          q_cmd
);

    logic [slbs_pkg::CNT_W-1:0] fill_reg;
    logic [slbs_pkg::CNT_W-1:0] fill_next;
    logic                       full;

    assign full    = (fill_reg == slbs_pkg::CNT_W'(slbs_pkg::DEPTH));
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.value = s_value;
        unique case ({full, s_last})
            2'b00:   q_cmd.kind = slbs_pkg::CMD_PUSH;
            2'b01:   q_cmd.kind = slbs_pkg::CMD_PUSH_LAST;
            2'b10:   q_cmd.kind = slbs_pkg::CMD_DROP;
            default: q_cmd.kind = slbs_pkg::CMD_DROP_LAST;
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        if (q_push) begin
            if (s_last) begin
                fill_next = '0;
            end else if (!full) begin
                fill_next = fill_reg + slbs_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/slbs_queue.sv
// Short command queue between front and back ends.
// Depends on slbs_pkg.
`default_nettype none
module slbs_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire slbs_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output slbs_pkg::cmd_t      pop_cmd,
    output logic                empty
);

    slbs_pkg::cmd_t               mem [slbs_pkg::QDEPTH];
    logic [slbs_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [slbs_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [slbs_pkg::QCNT_W-1:0]  level_reg;
    logic [slbs_pkg::QCNT_W-1:0]  level_next;
    logic                         do_push;
    logic                         do_pop;

    assign full    = (level_reg == slbs_pkg::QCNT_W'(slbs_pkg::QDEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb begin
        level_next = level_reg;
        if (do_push && !do_pop) begin
            level_next = level_reg + slbs_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            level_next = level_reg - slbs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + slbs_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + slbs_pkg::QPTR_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/slbs_back.sv
// Back end: stack of cells, odd-even compare-and-swap rounds, emission from the top.
// Depends on slbs_pkg; drains slbs_queue.
`default_nettype none
module slbs_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               sort_desc,
    input  wire logic                               q_empty,
    input  wire slbs_pkg::cmd_t                     q_cmd,
    output logic                                    q_pop,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [slbs_pkg::DATA_W-1:0]      m_sorted_value,
    output logic        [slbs_pkg::POS_W-1:0]       m_position,
    output logic                                    m_final_res,
    output logic                                    m_overflowed,
    output slbs_pkg::back_status_t                  status
);

    slbs_pkg::back_state_t             state_reg;
    slbs_pkg::back_state_t             state_next;
    logic signed [slbs_pkg::DATA_W-1:0] slot_reg  [slbs_pkg::DEPTH];
    logic signed [slbs_pkg::DATA_W-1:0] sort_slots[slbs_pkg::DEPTH];
    logic [slbs_pkg::CNT_W-1:0]        count_reg;
    logic [slbs_pkg::IDX_W-1:0]        round_reg;
    logic [slbs_pkg::IDX_W-1:0]        pos_reg;
    logic                              dropped_reg;
    logic                              is_push;
    logic                              is_last;
    logic                              sort_done;
    logic                              emit_done;
    logic                              emit_take;

    always_comb begin
        is_push = 1'b0;
        is_last = 1'b0;
        unique case (q_cmd.kind)
            slbs_pkg::CMD_PUSH:      is_push = 1'b1;
            slbs_pkg::CMD_PUSH_LAST: begin
                is_push = 1'b1;
                is_last = 1'b1;
            end
            slbs_pkg::CMD_DROP:      is_push = 1'b0;
            default:                 is_last = 1'b1;
        endcase
    end

    assign sort_done = (slbs_pkg::CNT_W'(round_reg) == count_reg - slbs_pkg::CNT_W'(1));
    assign emit_done = (slbs_pkg::CNT_W'(pos_reg) == count_reg - slbs_pkg::CNT_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            slbs_pkg::ST_LOAD: begin
                if (!q_empty && is_last) begin
                    state_next = slbs_pkg::ST_SORT;
                end
            end
            slbs_pkg::ST_SORT: begin
                if (sort_done) begin
                    state_next = slbs_pkg::ST_EMIT;
                end
            end
            slbs_pkg::ST_EMIT: begin
                if (m_ready && emit_done) begin
                    state_next = slbs_pkg::ST_LOAD;
                end
            end
            default: state_next = slbs_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        q_pop   = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            slbs_pkg::ST_LOAD: q_pop   = !q_empty;
            slbs_pkg::ST_SORT: q_pop   = 1'b0;
            slbs_pkg::ST_EMIT: m_valid = 1'b1;
            default:           q_pop   = 1'b0;
        endcase
    end

    assign emit_take      = m_valid && m_ready;
    assign m_sorted_value = slot_reg[0];
    assign m_position     = slbs_pkg::POS_W'(pos_reg);
    assign m_final_res    = emit_done;
    assign m_overflowed   = dropped_reg;
    assign status.state   = state_reg;
    assign status.count   = count_reg;

    // one compare-and-swap round over disjoint neighbour pairs
    always_comb begin
        for (int k = 0; k < slbs_pkg::DEPTH; k++) begin
            sort_slots[k] = slot_reg[k];
        end
        for (int k = 0; k < slbs_pkg::DEPTH - 1; k++) begin
            if ((1'(k) == round_reg[0]) &&
                (slbs_pkg::CNT_W'(k + 1) < count_reg) &&
                (sort_desc ? (slot_reg[k+1] > slot_reg[k])
                           : (slot_reg[k] > slot_reg[k+1]))) begin
                sort_slots[k]   = slot_reg[k+1];
                sort_slots[k+1] = slot_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && is_push) begin
            slot_reg[0] <= q_cmd.value;
            for (int k = 1; k < slbs_pkg::DEPTH; k++) begin
                slot_reg[k] <= slot_reg[k-1];
            end
        end else if (state_reg == slbs_pkg::ST_SORT) begin
            for (int k = 0; k < slbs_pkg::DEPTH; k++) begin
                slot_reg[k] <= sort_slots[k];
            end
        end else if (emit_take) begin
            for (int k = 0; k < slbs_pkg::DEPTH - 1; k++) begin
                slot_reg[k] <= slot_reg[k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slbs_pkg::ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            round_reg   <= '0;
            pos_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                if (is_push) begin
                    count_reg <= count_reg + slbs_pkg::CNT_W'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
                round_reg <= '0;
                pos_reg   <= '0;
            end
            if (state_reg == slbs_pkg::ST_SORT) begin
                round_reg <= round_reg + slbs_pkg::IDX_W'(1);
            end
            if (emit_take) begin
                pos_reg <= pos_reg + slbs_pkg::IDX_W'(1);
                if (emit_done) begin
                    count_reg   <= '0;
                    dropped_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/stack_load_bubble_sorter.sv
// Top level of the stack-load bubble sorter: APB register, front end, queue, back end.
// Depends on slbs_pkg, slbs_front, slbs_queue and slbs_back.
//
//  port group | role        | handshake              | payload
//  s_*        | numbers in  | s_valid / s_ready      | s_value, s_last
//  m_*        | results out | m_valid / m_ready      | m_sorted_value, m_position,
//             |             |                        | m_final_res, m_overflowed
//  p*         | register    | psel, penable, pwrite  | paddr, pwdata, prdata
//
// Numbers load from the queue into the stack cells one per cycle while the queue is not empty.
// A set of n numbers then takes n compare-and-swap rounds of the cell row, and
// results leave one per cycle while m_ready is high.
// The two-entry queue takes up to two numbers while the back end sorts or emits;
// s_ready then stays low until loading resumes.
// Reset clears the queue, count, flag and direction; the cells need no reset.
`default_nettype none
module stack_load_bubble_sorter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [slbs_pkg::DATA_W-1:0]  s_value,
    input  wire logic                                s_last,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [slbs_pkg::DATA_W-1:0]       m_sorted_value,
    output logic        [slbs_pkg::POS_W-1:0]        m_position,
    output logic                                     m_final_res,
    output logic                                     m_overflowed,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [slbs_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [slbs_pkg::PDATA_W-1:0]        pwdata,
    output logic      [slbs_pkg::PDATA_W-1:0]        prdata,
    output logic                                     pready
);

    logic                   sort_desc_reg;
    logic                   reg_sel;
    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_empty;
    slbs_pkg::cmd_t         push_cmd;
    slbs_pkg::cmd_t         pop_cmd;
    slbs_pkg::back_status_t back_status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[slbs_pkg::PADDR_W-1] == slbs_pkg::REG_SORT_DESC);
    assign prdata  = reg_sel ? {{(slbs_pkg::PDATA_W-1){1'b0}}, sort_desc_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_desc_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            sort_desc_reg <= pwdata[0];
        end
    end

    slbs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .s_last  (s_last),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    slbs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    slbs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sort_desc      (sort_desc_reg),
        .q_empty        (q_empty),
        .q_cmd          (pop_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_position     (m_position),
        .m_final_res    (m_final_res),
        .m_overflowed   (m_overflowed),
        .status         (back_status)
    );

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (back_status.count != '0))
        else $error("result shown with an empty stack");

    a_emit_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_final_res) |=>
            (m_valid && (sort_desc_reg ? ($past(m_sorted_value) >= m_sorted_value)
                                       : ($past(m_sorted_value) <= m_sorted_value))))
        else $error("results out of sorted order");

    a_position_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_final_res) |=>
            (m_position == slbs_pkg::POS_W'($past(m_position) + slbs_pkg::POS_W'(1))))
        else $error("position did not advance by one");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_res) |=> !m_valid)
        else $error("result shown after the final one");

endmodule
`default_nettype wire

// File: tb/tb_stack_load_bubble_sorter.sv
// Self-checking testbench for stack_load_bubble_sorter: pushes sets of signed numbers,
// predicts each sorted run and checks every result; direction register changes between
// phases. Depends on slbs_pkg and the block's RTL.
module tb_stack_load_bubble_sorter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD        = 300;
    localparam int SETTLE           = 20;
    localparam int RANDOM_PER_PHASE = 60;
    localparam int DIR_ROWS         = 11;

    localparam logic [slbs_pkg::PADDR_W-1:0] ADDR_SORT_DESC = {slbs_pkg::REG_SORT_DESC, 2'b00};
    localparam logic [slbs_pkg::PADDR_W-1:0] ADDR_NONE_LO   = 3'b100;
    localparam logic [slbs_pkg::PADDR_W-1:0] ADDR_NONE_HI   = 3'b111;

    typedef struct packed {
        logic signed [slbs_pkg::DATA_W-1:0] value;
        logic        [slbs_pkg::POS_W-1:0]  position;
        logic                               final_res;
        logic                               overflowed;
    } sorted_result_t;

    typedef struct packed {
        logic signed [slbs_pkg::DATA_W-1:0] value;
        logic signed [slbs_pkg::DATA_W-1:0] step;
        logic        [7:0]                  repeats;
        logic                               last;
        logic                               typed;
    } dir_row_t;

    // a typed row is a one-number set: its single result is the number itself
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{32'sh8000_0000, 0, 1, 1'b1, 1'b1},
        '{32'sh7FFF_FFFF, 0, 1, 1'b1, 1'b1},
        '{0,              0, 1, 1'b1, 1'b1},
        '{-1,             0, 1, 1'b1, 1'b1},
        '{5,              0, 1, 1'b0, 1'b0},
        '{-3,             0, 1, 1'b0, 1'b0},
        '{5,              0, 1, 1'b0, 1'b0},
        '{32'sh7FFF_FFFF, 0, 1, 1'b0, 1'b0},
        '{32'sh8000_0000, 0, 1, 1'b0, 1'b0},
        '{0,              0, 1, 1'b1, 1'b0},
        '{100,          -13, 17, 1'b1, 1'b0}
    };

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic signed [slbs_pkg::DATA_W-1:0]   s_value;
    logic                                 s_last;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [slbs_pkg::DATA_W-1:0]   m_sorted_value;
    logic        [slbs_pkg::POS_W-1:0]    m_position;
    logic                                 m_final_res;
    logic                                 m_overflowed;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic        [slbs_pkg::PADDR_W-1:0]  paddr;
    logic        [slbs_pkg::PDATA_W-1:0]  pwdata;
    logic        [slbs_pkg::PDATA_W-1:0]  prdata;
    logic                                 pready;

    logic signed [slbs_pkg::DATA_W-1:0]   stack_mem [slbs_pkg::DEPTH];
    int                                   stack_count = 0;
    logic                                 drop_seen = 1'b0;
    logic                                 desc_order = 1'b0;
    sorted_result_t                       sorted_due [$];
    int                                   error_count = 0;
    int                                   idle_cycles = 0;
    int                                   burst_left = 0;
    bit                                   long_hold_req = 1'b0;

    stack_load_bubble_sorter dut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic push_or_sort(input logic signed [slbs_pkg::DATA_W-1:0] v, input logic l,
                                input bit keep);
        logic signed [slbs_pkg::DATA_W-1:0] ranked [slbs_pkg::DEPTH];
        logic signed [slbs_pkg::DATA_W-1:0] t;
        sorted_result_t                     r;
        int                                 n;
        int                                 lim;
        bit                                 swapped;
        bit                                 swap_now;
        if (stack_count < slbs_pkg::DEPTH) begin
            stack_mem[stack_count] = v;
            stack_count++;
        end else begin
            drop_seen = 1'b1;
        end
        if (!l) return;
        n = stack_count;
        for (int i = 0; i < n; i++) ranked[i] = stack_mem[n - 1 - i];
        lim = n;
        swapped = 1'b1;
        while (swapped && lim > 1) begin
            swapped = 1'b0;
            for (int i = 0; i + 1 < lim; i++) begin
                swap_now = desc_order ? (ranked[i + 1] > ranked[i])
                                      : (ranked[i] > ranked[i + 1]);
                if (swap_now) begin
                    t = ranked[i];
                    ranked[i] = ranked[i + 1];
                    ranked[i + 1] = t;
                    swapped = 1'b1;
                end
            end
            lim--;
        end
        if (keep) begin
            for (int i = 0; i < n; i++) begin
                r.value      = ranked[i];
                r.position   = slbs_pkg::POS_W'(i);
                r.final_res  = (i == n - 1);
                r.overflowed = drop_seen;
                sorted_due.push_back(r);
            end
        end
        stack_count = 0;
        drop_seen = 1'b0;
    endtask

    function automatic logic signed [slbs_pkg::DATA_W-1:0] random_number();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(slbs_pkg::DATA_W - 1){1'b0}}};
            1: return {1'b0, {(slbs_pkg::DATA_W - 1){1'b1}}};
            2: return int'($urandom_range(0, 16)) - 8;
            3: return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic offer_number(input logic signed [slbs_pkg::DATA_W-1:0] v, input logic l,
                                input bit keep);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk) s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= l;
        do @(posedge aclk); while (!s_ready);
        push_or_sort(v, l, keep);
    endtask

    task automatic drain_results();
        @(negedge aclk) s_valid <= 1'b0;
        burst_left = 0;
        while (sorted_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [slbs_pkg::PADDR_W-1:0] addr,
                             input logic [slbs_pkg::PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if ((addr >> 2) == slbs_pkg::PADDR_W'(slbs_pkg::REG_SORT_DESC)) desc_order = data[0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_check();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SORT_DESC;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(slbs_pkg::PDATA_W - 1){1'b0}}, desc_order}) begin
            $display("%0t: direction readback expected %0h, got %0h",
                     $time, desc_order, prdata);
            error_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_phase(input int target, input bit press);
        int sent;
        int len;
        int set_no;
        sent = 0;
        set_no = 0;
        while (sent < target) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(slbs_pkg::DEPTH + 1, slbs_pkg::DEPTH + 8);
                1: len = 1;
                default: len = $urandom_range(2, slbs_pkg::DEPTH);
            endcase
            if (press && set_no == 0) begin
                long_hold_req = 1'b1;
                len = slbs_pkg::DEPTH + 6;
            end
            for (int k = 0; k < len; k++) offer_number(random_number(), k == len - 1, 1'b1);
            sent += len;
            set_no++;
            if (set_no == 3 || $urandom_range(0, 7) == 0) drain_results();
        end
    endtask

    initial begin
        logic signed [slbs_pkg::DATA_W-1:0] v;
        logic                               l;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_value = '0;
        s_last  = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        reg_check();
        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].repeats; k++) begin
                v = dir_rows[r].value + k * dir_rows[r].step;
                l = dir_rows[r].last && (k == dir_rows[r].repeats - 1);
                offer_number(v, l, !dir_rows[r].typed);
                if (dir_rows[r].typed) sorted_due.push_back('{v, '0, 1'b1, 1'b0});
            end
        end

        drain_results();
        reg_write(ADDR_SORT_DESC, '1);
        reg_write(ADDR_NONE_LO, '0);
        reg_check();
        random_phase(RANDOM_PER_PHASE, 1'b1);

        drain_results();
        reg_write(ADDR_SORT_DESC, 32'hFFFF_FFFE);
        reg_write(ADDR_NONE_HI, 32'h0000_0001);
        reg_check();
        random_phase(RANDOM_PER_PHASE, 1'b0);

        drain_results();
        reg_write(ADDR_SORT_DESC, 32'h0000_0001);
        reg_check();
        random_phase(RANDOM_PER_PHASE, 1'b0);

        drain_results();
        repeat (40) @(posedge aclk);
        if (sorted_due.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hold off in long stretches on request, otherwise stall on a random pattern
    initial begin
        int span;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                @(negedge aclk) m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else begin
                span = $urandom_range(5, 60);
                case ($urandom_range(0, 3))
                    0: repeat (span) @(negedge aclk) m_ready <= 1'b1;
                    1: repeat (span) @(negedge aclk) m_ready <= 1'($urandom_range(0, 1));
                    2: repeat (span) @(negedge aclk) m_ready <= ($urandom_range(0, 4) != 0);
                    default: repeat ($urandom_range(1, 12)) @(negedge aclk) m_ready <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        sorted_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sorted_due.size() == 0) begin
                $display("%0t: unexpected result value=%0d position=%0d",
                         $time, m_sorted_value, m_position);
                error_count++;
            end else begin
                want = sorted_due.pop_front();
                if (want !== {m_sorted_value, m_position, m_final_res, m_overflowed}) begin
                    $display("%0t: expected value=%0d position=%0d final=%0b overflow=%0b",
                             $time, want.value, want.position, want.final_res,
                             want.overflowed);
                    $display("%0t: actual   value=%0d position=%0d final=%0b overflow=%0b",
                             $time, m_sorted_value, m_position, m_final_res, m_overflowed);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
